// File: sv/bwt_pkg.sv
// Shared types and constants for the burst window trigger.
// Holds the history depth, field widths, register codes and reset values.
// No dependencies.
package bwt_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
  localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);

  localparam int TIME_W = 63;
  localparam int WIN_W  = 40;
  localparam int THR_W  = 5;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_SEL_LSB = 3;
  localparam int CFG_SEL_W   = 2;

  typedef logic [TIME_W-1:0] time_ns_t;
  typedef logic [WIN_W-1:0]  window_t;
  typedef logic [THR_W-1:0]  thresh_t;

  typedef enum logic [CFG_SEL_W-1:0] {
    REG_WINDOW    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_START     = 2'd2
  } cfg_reg_t;

  localparam window_t  WINDOW_RESET = 40'd10000000000;
  localparam thresh_t  THRESH_RESET = 5'd2;
  localparam time_ns_t START_RESET  = '0;

endpackage

// File: sv/burst_window_trigger_unit.sv
// Burst window trigger: top level with ring history, trigger logic and register port.
// Depends on bwt_pkg.
//
// The block takes one event timestamp (nanoseconds, time ordered) per request and
// raises an alert request carrying that timestamp when the event is later than the
// current time, at least count_threshold earlier events are held, and the span back
// to the event count_threshold places earlier is strictly below window_ns. Events
// that are not later than the current time are only recorded as history. One event
// is accepted every clock cycle; only an event that raises an alert while an earlier
// alert is still stalled on the output has to wait. An accepted event is held in the event
// register and evaluated there; if it raises an alert, it moves into the alert register
// that drives out_valid, and a stalled earlier alert can hold it in the event register.
// The evaluation stage is a single read of the 16-entry history ring, one 63-bit
// subtract and the 63-bit compares against the window and the current time, all
// between the event register and the alert register. The ring, its write
// pointer and fill count are updated in the same cycle an event is evaluated, so a
// following event sees them at once. Registers sit on the 64-bit APB-style port at
// byte offsets 0 (window_ns), 8 (count_threshold) and 16 (start_time_ns); writing
// start_time_ns also loads the current time and must only be done while idle.
module burst_window_trigger_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // Event input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bwt_pkg::time_ns_t                in_event_time,
  // Alert output channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output bwt_pkg::time_ns_t                out_alert_time,
  // Register port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bwt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bwt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bwt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import bwt_pkg::*;

  localparam int CMP_W = (THR_W > HIST_CNT_W) ? THR_W : HIST_CNT_W;
  localparam int IDX_EXT_W = ((HIST_IDX_W > THR_W) ? HIST_IDX_W : THR_W) + 2;

  // Configuration registers.
  window_t  window_r;
  thresh_t  thresh_r;
  time_ns_t start_r;

  // Trigger state.
  time_ns_t                ring_r [HIST_DEPTH];
  logic [HIST_IDX_W-1:0]   wp_r;
  logic [HIST_IDX_W-1:0]   wp_nxt;
  logic [HIST_CNT_W-1:0]   cnt_r;
  logic [HIST_CNT_W-1:0]   cnt_nxt;
  time_ns_t                cur_r;

  // Event stage and alert stage.
  logic     ev_valid_r;
  time_ns_t ev_time_r;
  logic     out_valid_r;
  time_ns_t out_time_r;

  // Evaluation logic.
  cfg_reg_t              cfg_sel;
  logic                  cfg_wr;
  logic                  is_later;
  logic                  enough_hist;
  logic [IDX_EXT_W-1:0]  idx_ext;
  logic [HIST_IDX_W-1:0] rd_idx;
  time_ns_t              older;
  time_ns_t              span;
  logic                  alert;
  logic                  process;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[CFG_SEL_LSB +: CFG_SEL_W]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_sel)
      REG_WINDOW:    prdata = CFG_DATA_W'(window_r);
      REG_THRESHOLD: prdata = CFG_DATA_W'(thresh_r);
      REG_START:     prdata = CFG_DATA_W'(start_r);
      default:       prdata = '0;
    endcase
  end

  // The entry count_threshold places behind the write pointer. It is only used
  // when the fill count shows that entry was written, so the threshold is then
  // at most the depth and one conditional add of the depth covers the wrap.
  always_comb begin
    if (IDX_EXT_W'(wp_r) >= IDX_EXT_W'(thresh_r)) begin
      idx_ext = IDX_EXT_W'(wp_r) - IDX_EXT_W'(thresh_r);
    end else begin
      idx_ext = IDX_EXT_W'(wp_r) + IDX_EXT_W'(HIST_DEPTH) - IDX_EXT_W'(thresh_r);
    end
  end
  assign rd_idx = idx_ext[HIST_IDX_W-1:0];

  // A threshold of zero compares the event with itself, giving a span of zero.
  assign older       = (thresh_r == '0) ? ev_time_r : ring_r[rd_idx];
  assign span        = ev_time_r - older;
  assign is_later    = ev_time_r > cur_r;
  assign enough_hist = CMP_W'(thresh_r) <= CMP_W'(cnt_r);

  // An older entry later than the new event only follows out-of-order input; the
  // span is then negative and below any window.
  assign alert = is_later && enough_hist &&
                 ((older > ev_time_r) || (span < TIME_W'(window_r)));

  // An event without an alert never waits for the output side.
  assign process  = ev_valid_r && (!out_valid_r || !out_stall || !alert);
  assign in_stall = ev_valid_r && !process;

  assign out_valid      = out_valid_r;
  assign out_alert_time = out_time_r;

  always_comb begin
    if (wp_r == HIST_IDX_W'(HIST_DEPTH - 1)) begin
      wp_nxt = '0;
    end else begin
      wp_nxt = wp_r + 1'b1;
    end
    if (cnt_r == HIST_CNT_W'(HIST_DEPTH)) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RESET;
      thresh_r    <= THRESH_RESET;
      start_r     <= START_RESET;
      cur_r       <= START_RESET;
      wp_r        <= '0;
      cnt_r       <= '0;
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        ev_valid_r <= 1'b1;
      end else if (process) begin
        ev_valid_r <= 1'b0;
      end

      if (process && alert) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (process) begin
        wp_r  <= wp_nxt;
        cnt_r <= cnt_nxt;
        if (is_later) begin
          cur_r <= ev_time_r;
        end
      end

      if (cfg_wr) begin
        unique case (cfg_sel)
          REG_WINDOW:    window_r <= pwdata[WIN_W-1:0];
          REG_THRESHOLD: thresh_r <= pwdata[THR_W-1:0];
          REG_START: begin
            start_r <= pwdata[TIME_W-1:0];
            cur_r   <= pwdata[TIME_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers and the history ring carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ev_time_r <= in_event_time;
    end
    if (process) begin
      ring_r[wp_r] <= ev_time_r;
    end
    if (process && alert) begin
      out_time_r <= ev_time_r;
    end
  end

endmodule

// File: sv/bwt_checker.sv
// Port-level checker for the burst window trigger, bound to the top level.
// Depends on bwt_pkg and burst_window_trigger_unit.
module bwt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input bwt_pkg::time_ns_t                out_alert_time
);
  import bwt_pkg::*;

  // A stalled alert holds its timestamp.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_alert_time))
    else $error("alert changed while stalled");

  // The input side only stalls behind an alert that is itself stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled alert");

  // A fresh alert comes from an event taken earlier at the input.
  a_alert_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("alert without a matching event");

  // Reset leaves no alert pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("alert present after reset");

endmodule

bind burst_window_trigger_unit bwt_checker u_bwt_checker (.*);
